// ----- rtl/assert_macros.svh -----
// assertion helpers for the watchdog table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TWT_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("watchdog table assertion failed");
`define TWT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("watchdog table forbidden condition");
`else
`define TWT_ASSERT(label, clk, rstn, prop)
`define TWT_NEVER(label, clk, rstn, expr)
`endif

`endif

// ----- rtl/twt_pkg.sv -----
`default_nettype none

package twt_pkg;

  localparam int TWT_MAX_CLIENTS = 10;
  localparam int ID_W            = 16;
  localparam int TIME_W          = 32;

  typedef enum logic [1:0] {
    FN_CLEAR    = 2'd0,
    FN_REGISTER = 2'd1,
    FN_KICK     = 2'd2,
    FN_CHECK    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FAIL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_REPLY
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic reply;
  } twt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic empty;
    logic last;
  } twt_sts_t;

endpackage

`default_nettype wire

// ----- rtl/twt_ctrl.sv -----
`default_nettype none

module twt_ctrl import twt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  twt_sts_t sts,
  output twt_cmd_t cmd,
  output logic     busy
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.skip) begin
          state_nxt = S_REPLY;
        end else if (sts.empty) begin
          state_nxt = S_WAIT;
        end else begin
          cmd.issue = 1'b1;
          if (sts.last) begin
            state_nxt = S_WAIT;
          end
        end
      end
      // last read is evaluated here
      S_WAIT: begin
        state_nxt = S_REPLY;
      end
      S_REPLY: begin
        cmd.reply = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/twt_dpath.sv -----
`default_nettype none

module twt_dpath import twt_pkg::*; #(
  parameter int MAX_CLIENTS = TWT_MAX_CLIENTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  twt_cmd_t          cmd,
  output twt_sts_t          sts,
  input  logic [1:0]        in_func,
  input  logic [ID_W-1:0]   in_client_id,
  input  logic [TIME_W-1:0] in_timeout_limit,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic              in_time_valid,
  output logic              out_strobe,
  output logic [1:0]        out_op_status,
  output logic              out_timeout_seen,
  output logic              out_io_error
);

  localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
  localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

  // entry storage
  logic [ID_W-1:0]   id_mem     [MAX_CLIENTS];
  logic              kicked_mem [MAX_CLIENTS];
  logic [TIME_W-1:0] last_mem   [MAX_CLIENTS];
  logic [TIME_W-1:0] tmo_mem    [MAX_CLIENTS];

  func_t             op_r;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] tmo_r;
  logic [TIME_W-1:0] now_r;
  logic              tvalid_r;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  idx_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              rd_vld_r;
  logic [ID_W-1:0]   rd_id_r;
  logic              rd_kicked_r;
  logic [TIME_W-1:0] rd_last_r;
  logic [TIME_W-1:0] rd_tmo_r;
  logic              hit_r;
  logic              seen_r;

  logic              out_vld_r;
  logic [1:0]        out_status_r;
  logic              out_seen_r;
  logic              out_ioerr_r;

  logic              params_bad;
  logic              full;
  logic              match;
  logic              kick_hit;
  logic              reg_dup;
  logic              chk_eval;
  logic [TIME_W-1:0] elapsed;
  logic              timed_out;
  logic              reg_ok;
  logic              append;
  logic [IDX_W-1:0]  wr_idx;
  logic              kicked_we;
  logic              last_we;
  status_t           status;

  assign params_bad = (id_r == '0) || (tmo_r == '0);
  assign full       = (count_r == CNT_W'(MAX_CLIENTS));
  assign match      = rd_vld_r && (rd_id_r == id_r);
  assign kick_hit   = (op_r == FN_KICK) && tvalid_r && match && !hit_r;
  assign reg_dup    = (op_r == FN_REGISTER) && match;
  assign chk_eval   = (op_r == FN_CHECK) && rd_vld_r;
  assign elapsed    = now_r - rd_last_r;
  assign timed_out  = chk_eval && !rd_kicked_r && (elapsed > rd_tmo_r);
  assign reg_ok     = (op_r == FN_REGISTER) && !params_bad && !full && !hit_r;
  assign append     = cmd.reply && reg_ok;
  assign wr_idx     = append ? count_r[IDX_W-1:0] : rd_idx_r;
  assign kicked_we  = append || kick_hit || chk_eval;
  assign last_we    = append || kick_hit;

  assign sts.skip  = (op_r == FN_CLEAR) ||
                     ((op_r == FN_REGISTER) && (params_bad || full));
  assign sts.empty = (count_r == '0);
  assign sts.last  = (CNT_W'(idx_r + 1'b1) == count_r);

  always_comb begin
    status = ST_OK;
    case (op_r)
      FN_REGISTER: begin
        if (params_bad) begin
          status = ST_INVALID;
        end else if (full || hit_r || !tvalid_r) begin
          status = ST_FAIL;
        end
      end
      FN_KICK: begin
        status = hit_r ? ST_OK : ST_FAIL;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // latched operation fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= func_t'(in_func);
      id_r     <= in_client_id;
      tmo_r    <= in_timeout_limit;
      now_r    <= in_time_valid ? in_now_ms : '0;
      tvalid_r <= in_time_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      rd_vld_r  <= 1'b0;
      hit_r     <= 1'b0;
      seen_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.issue;
      out_vld_r <= cmd.reply;
      if (cmd.load) begin
        idx_r  <= '0;
        hit_r  <= 1'b0;
        seen_r <= 1'b0;
      end else begin
        if (cmd.issue) begin
          idx_r <= idx_r + 1'b1;
        end
        hit_r  <= hit_r | kick_hit | reg_dup;
        seen_r <= seen_r | timed_out;
      end
      if (cmd.reply && (op_r == FN_CLEAR)) begin
        count_r <= '0;
      end else if (append) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // scan read port, registered
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_idx_r    <= idx_r[IDX_W-1:0];
      rd_id_r     <= id_mem[idx_r[IDX_W-1:0]];
      rd_kicked_r <= kicked_mem[idx_r[IDX_W-1:0]];
      rd_last_r   <= last_mem[idx_r[IDX_W-1:0]];
      rd_tmo_r    <= tmo_mem[idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (append) begin
      id_mem[wr_idx]  <= id_r;
      tmo_mem[wr_idx] <= tmo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (kicked_we) begin
      kicked_mem[wr_idx] <= !chk_eval;
    end
  end

  always_ff @(posedge clk) begin
    if (last_we) begin
      last_mem[wr_idx] <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reply) begin
      out_status_r <= status;
      out_seen_r   <= (op_r == FN_CHECK) && seen_r;
      out_ioerr_r  <= (op_r == FN_CHECK) && !tvalid_r;
    end
  end

  assign out_strobe       = out_vld_r;
  assign out_op_status    = out_status_r;
  assign out_timeout_seen = out_seen_r;
  assign out_io_error     = out_ioerr_r;

endmodule

`default_nettype wire

// ----- rtl/task_watchdog_table_core.sv -----
// channel   | ports                                            | handshake
// ----------+--------------------------------------------------+---------------------------
// command   | in_func in_client_id in_timeout_limit in_now_ms  | start high, busy low
//           | in_time_valid                                    |
// result    | out_op_status out_timeout_seen out_io_error      | out_strobe, one cycle
//
// a scan visits the live entries in order, then waits for the last read and replies; clear
// and registers rejected for bad parameters or a full table skip the scan and go to the reply
// the scan reads one table entry per cycle through a single registered read port
// busy falls in the cycle the result strobe is high, so the next command can follow
// synchronous active-low reset empties the table; entry contents are not cleared
// the result is offered for one cycle only, the receiver cannot stall
`default_nettype none

`include "assert_macros.svh"

module task_watchdog_table_core import twt_pkg::*; #(
  parameter int MAX_CLIENTS = TWT_MAX_CLIENTS
) (
  input  logic              clk,
  input  logic              rst_n,
  // command side
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_func,
  input  logic [ID_W-1:0]   in_client_id,
  input  logic [TIME_W-1:0] in_timeout_limit,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic              in_time_valid,
  // result side
  output logic              out_strobe,
  output logic [1:0]        out_op_status,
  output logic              out_timeout_seen,
  output logic              out_io_error
);

  // commands and status between sequencer and table datapath
  twt_cmd_t cmd;
  twt_sts_t sts;

  // sequencer: load, scan, wait for the last read, reply
  twt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // entry table, scan comparator, append and result registers
  twt_dpath #(
    .MAX_CLIENTS (MAX_CLIENTS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_client_id     (in_client_id),
    .in_timeout_limit (in_timeout_limit),
    .in_now_ms        (in_now_ms),
    .in_time_valid    (in_time_valid),
    .out_strobe       (out_strobe),
    .out_op_status    (out_op_status),
    .out_timeout_seen (out_timeout_seen),
    .out_io_error     (out_io_error)
  );

  // a transfer always makes the block busy on the next cycle
  `TWT_ASSERT(a_busy_after_transfer, clk, rst_n, (start && !busy) |=> busy)
  // the result is never given in the cycle right after a transfer
  `TWT_ASSERT(a_no_instant_result, clk, rst_n, (start && !busy) |=> !out_strobe)
  // exactly one strobe per operation, released together with busy
  `TWT_ASSERT(a_strobe_single, clk, rst_n, out_strobe |=> !out_strobe)
  `TWT_NEVER(a_strobe_while_busy, clk, rst_n, out_strobe && busy)

endmodule

`default_nettype wire

// ----- tb/task_watchdog_table_core_tb.sv -----
module task_watchdog_table_core_tb;
  import twt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = TWT_MAX_CLIENTS;
  // settle time after the last strobe: longest scan plus a margin
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 10;
  localparam int RANDOM_ITEMS = 1650;
  localparam int POOL_SIZE = 12;

  // one command as presented on the in_ ports
  typedef struct {
    func_t       func;
    logic [15:0] client_id;
    logic [31:0] timeout_limit;
    logic [31:0] now_ms;
    logic        time_valid;
  } wd_cmd_t;

  // one reply as expected on the out_ ports
  typedef struct {
    status_t op_status;
    logic    timeout_seen;
    logic    io_error;
  } wd_reply_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_func;
  logic [ID_W-1:0]   in_client_id;
  logic [TIME_W-1:0] in_timeout_limit;
  logic [TIME_W-1:0] in_now_ms;
  logic              in_time_valid;
  logic              out_strobe;
  logic [1:0]        out_op_status;
  logic              out_timeout_seen;
  logic              out_io_error;

  // commands waiting to be driven, replies waiting to arrive
  wd_cmd_t   cmd_queue[$];
  wd_reply_t reply_queue[$];

  // predicted watchdog table
  logic [15:0] tbl_id[TABLE_DEPTH];
  logic        tbl_kicked[TABLE_DEPTH];
  logic [31:0] tbl_last_kick[TABLE_DEPTH];
  logic [31:0] tbl_timeout[TABLE_DEPTH];
  int          tbl_count;

  int   err_count;
  int   total_cmds;
  int   launched_cmds;
  int   accepted_cmds;
  logic took;

  task_watchdog_table_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_client_id     (in_client_id),
    .in_timeout_limit (in_timeout_limit),
    .in_now_ms        (in_now_ms),
    .in_time_valid    (in_time_valid),
    .out_strobe       (out_strobe),
    .out_op_status    (out_op_status),
    .out_timeout_seen (out_timeout_seen),
    .out_io_error     (out_io_error)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // applies one command to the predicted table and returns the reply it gives
  function automatic wd_reply_t apply_watchdog_op(input wd_cmd_t c);
    wd_reply_t   r;
    logic        found;
    logic [31:0] t;
    logic [31:0] elapsed;
    r.op_status = ST_OK;
    r.timeout_seen = 1'b0;
    r.io_error = 1'b0;
    found = 1'b0;
    case (c.func)
      FN_CLEAR: begin
        tbl_count = 0;
      end
      FN_REGISTER: begin
        // parameter check first, then capacity, then duplicate id
        for (int k = 0; k < tbl_count; k++) begin
          if (tbl_id[k] == c.client_id) found = 1'b1;
        end
        if (c.client_id == '0 || c.timeout_limit == '0) begin
          r.op_status = ST_INVALID;
        end else if (tbl_count >= TABLE_DEPTH) begin
          r.op_status = ST_FAIL;
        end else if (found) begin
          r.op_status = ST_FAIL;
        end else begin
          // appended even with a bad time source, stamped at zero
          tbl_id[tbl_count] = c.client_id;
          tbl_kicked[tbl_count] = 1'b1;
          tbl_last_kick[tbl_count] = c.time_valid ? c.now_ms : '0;
          tbl_timeout[tbl_count] = c.timeout_limit;
          tbl_count++;
          r.op_status = c.time_valid ? ST_OK : ST_FAIL;
        end
      end
      FN_KICK: begin
        r.op_status = ST_FAIL;
        if (c.time_valid) begin
          // first matching entry only
          for (int k = 0; k < tbl_count; k++) begin
            if (!found && tbl_id[k] == c.client_id) begin
              tbl_kicked[k] = 1'b1;
              tbl_last_kick[k] = c.now_ms;
              r.op_status = ST_OK;
              found = 1'b1;
            end
          end
        end
      end
      default: begin
        // check: bad time source reads as time zero, scan still runs
        t = c.time_valid ? c.now_ms : '0;
        r.io_error = ~c.time_valid;
        for (int k = 0; k < tbl_count; k++) begin
          elapsed = t - tbl_last_kick[k];
          if (!tbl_kicked[k] && elapsed > tbl_timeout[k]) r.timeout_seen = 1'b1;
          tbl_kicked[k] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic queue_cmd(input func_t f, input logic [15:0] id, input logic [31:0] tmo,
                           input logic [31:0] now, input logic tv);
    wd_cmd_t c;
    c.func = f;
    c.client_id = id;
    c.timeout_limit = tmo;
    c.now_ms = now;
    c.time_valid = tv;
    cmd_queue.push_back(c);
  endtask

  // driver: new command at the falling edge once the last one has been transferred
  always @(negedge clk) begin
    wd_cmd_t c;
    int      idle_pct;
    // sender idles 28 in a hundred, then 53, then not at all
    if (launched_cmds * 3 < total_cmds) idle_pct = 28;
    else if (launched_cmds * 3 < total_cmds * 2) idle_pct = 53;
    else idle_pct = 0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        c = cmd_queue.pop_front();
        start <= 1'b1;
        in_func <= c.func;
        in_client_id <= c.client_id;
        in_timeout_limit <= c.timeout_limit;
        in_now_ms <= c.now_ms;
        in_time_valid <= c.time_valid;
        launched_cmds++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check the strobe first, then record any transfer at the same edge,
  // so a reply and the next command's transfer in one cycle never cross
  always @(posedge clk) begin
    wd_reply_t exp_r;
    wd_cmd_t   c;
    if (out_strobe) begin
      if (reply_queue.size() == 0) begin
        $error("unexpected result strobe with no command outstanding");
        err_count++;
      end else begin
        exp_r = reply_queue.pop_front();
        if (out_op_status !== exp_r.op_status) begin
          $error("op_status: expected %0d, got %0d", exp_r.op_status, out_op_status);
          err_count++;
        end
        if (out_timeout_seen !== exp_r.timeout_seen) begin
          $error("timeout_seen: expected %0d, got %0d", exp_r.timeout_seen,
                 out_timeout_seen);
          err_count++;
        end
        if (out_io_error !== exp_r.io_error) begin
          $error("io_error: expected %0d, got %0d", exp_r.io_error, out_io_error);
          err_count++;
        end
      end
    end
    took <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      c.func = func_t'(in_func);
      c.client_id = in_client_id;
      c.timeout_limit = in_timeout_limit;
      c.now_ms = in_now_ms;
      c.time_valid = in_time_valid;
      reply_queue.push_back(apply_watchdog_op(c));
      accepted_cmds++;
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [15:0] id_pool[POOL_SIZE];
    logic [31:0] gen_now;
    logic [15:0] id;
    logic [31:0] tmo;
    logic        tv;
    int          epoch_len;
    int          pick;
    int          n;

    rst_n = 1'b0;
    start = 1'b0;
    took = 1'b0;
    in_func = '0;
    in_client_id = '0;
    in_timeout_limit = '0;
    in_now_ms = '0;
    in_time_valid = 1'b0;
    err_count = 0;
    launched_cmds = 0;
    accepted_cmds = 0;
    tbl_count = 0;
    total_cmds = 0;

    // directed: empty table behaviour
    queue_cmd(FN_CHECK, 16'h0000, 32'h0, 32'h0, 1'b1);
    queue_cmd(FN_KICK, 16'h0001, 32'h0, 32'h10, 1'b1);
    // invalid parameters, id zero and timeout zero
    queue_cmd(FN_REGISTER, 16'h0000, 32'h5, 32'h0, 1'b1);
    queue_cmd(FN_REGISTER, 16'h0007, 32'h0, 32'h0, 1'b1);
    // extremes of id, timeout and time
    queue_cmd(FN_REGISTER, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_cmd(FN_REGISTER, 16'hFFFF, 32'h1, 32'h0, 1'b1);
    // register with a bad time source still appends, stamped at zero
    queue_cmd(FN_REGISTER, 16'h0001, 32'h1, 32'h1234, 1'b0);
    // kick with bad time, kick of an unknown id
    queue_cmd(FN_KICK, 16'h0001, 32'h0, 32'h2, 1'b0);
    queue_cmd(FN_KICK, 16'h1234, 32'h0, 32'h2, 1'b1);
    // first check clears kicked flags, second sees id 1 overrun, id FFFF wraps but stays in time
    queue_cmd(FN_CHECK, 16'h0, 32'h0, 32'h5, 1'b1);
    queue_cmd(FN_CHECK, 16'h0, 32'h0, 32'h5, 1'b1);
    // check with bad time source
    queue_cmd(FN_CHECK, 16'h0, 32'h0, 32'hDEAD_BEEF, 1'b0);
    // fill the table, then full with bad params, full, full with duplicate
    for (int k = 2; k < 10; k++) queue_cmd(FN_REGISTER, 16'(k), 32'h40, 32'h100, 1'b1);
    queue_cmd(FN_REGISTER, 16'h0000, 32'h40, 32'h100, 1'b1);
    queue_cmd(FN_REGISTER, 16'h0077, 32'h40, 32'h100, 1'b1);
    queue_cmd(FN_REGISTER, 16'h0002, 32'h40, 32'h100, 1'b1);
    queue_cmd(FN_KICK, 16'h0009, 32'h0, 32'h0000_0003, 1'b1);
    // clear, then stale ids are gone
    queue_cmd(FN_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_cmd(FN_KICK, 16'h0002, 32'h0, 32'h200, 1'b1);
    // elapsed equal to timeout is not an overrun, one more tick is
    queue_cmd(FN_REGISTER, 16'h0055, 32'd10, 32'd100, 1'b1);
    queue_cmd(FN_CHECK, 16'h0, 32'h0, 32'd110, 1'b1);
    queue_cmd(FN_CHECK, 16'h0, 32'h0, 32'd110, 1'b1);
    queue_cmd(FN_CHECK, 16'h0, 32'h0, 32'd111, 1'b1);

    // random epochs: clear, then a mix over a small id pool so that duplicates,
    // a full table and overruns all come up
    n = 0;
    while (n < RANDOM_ITEMS) begin
      queue_cmd(FN_CLEAR, 16'($urandom), $urandom, $urandom, 1'($urandom));
      n++;
      for (int k = 0; k < POOL_SIZE; k++) begin
        pick = $urandom_range(9);
        if (pick == 0) id_pool[k] = 16'hFFFF;
        else if (pick < 4) id_pool[k] = 16'($urandom_range(1, 20));
        else id_pool[k] = 16'($urandom_range(1, 65535));
      end
      gen_now = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 : $urandom;
      epoch_len = $urandom_range(20, 120);
      for (int j = 0; j < epoch_len && n < RANDOM_ITEMS; j++) begin
        gen_now = gen_now + 32'($urandom_range(0, 40));
        tv = ($urandom_range(99) < 90);
        pick = $urandom_range(99);
        if (pick < 30) begin
          id = ($urandom_range(19) == 0) ? 16'h0 : id_pool[$urandom_range(POOL_SIZE - 1)];
          pick = $urandom_range(99);
          if (pick < 80) tmo = 32'($urandom_range(1, 150));
          else if (pick < 90) tmo = $urandom;
          else if (pick < 95) tmo = 32'h0;
          else tmo = 32'hFFFF_FFFF;
          queue_cmd(FN_REGISTER, id, tmo, gen_now, tv);
        end else if (pick < 65) begin
          id = ($urandom_range(19) == 0) ? 16'($urandom) : id_pool[$urandom_range(POOL_SIZE - 1)];
          queue_cmd(FN_KICK, id, $urandom, gen_now, tv);
        end else if (pick < 92) begin
          queue_cmd(FN_CHECK, 16'($urandom), $urandom, gen_now, tv);
        end else if (pick < 95) begin
          queue_cmd(FN_CLEAR, 16'($urandom), $urandom, gen_now, tv);
        end else begin
          // noise: every field at random
          queue_cmd(func_t'($urandom_range(3)), 16'($urandom), $urandom, $urandom,
                    1'($urandom));
        end
        n++;
      end
    end
    total_cmds = cmd_queue.size();

    // synchronous reset, released at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_cmds < total_cmds) @(posedge clk);
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/twt_pkg.sv
rtl/twt_ctrl.sv
rtl/twt_dpath.sv
rtl/task_watchdog_table_core.sv
tb/task_watchdog_table_core_tb.sv
